// File: hw/rtl/sensor_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// Sensor frame deframer assertion macros
// Shared concurrent assertion forms, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_DEFRAMER_DEFINES_SVH
`define SENSOR_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication.
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame deframer package
// Frame layout constants, status codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    localparam int POS_W         = 5;
    localparam int PAYLOAD_BYTES = 18;
    localparam int READINGS      = 9;

    localparam logic [7:0]       SYNC_BYTE      = 8'h80;
    localparam logic [7:0]       SYNC_SUM       = SYNC_BYTE + SYNC_BYTE;
    localparam logic [7:0]       TRAILER_FIRST  = 8'h0D;
    localparam logic [7:0]       TRAILER_SECOND = 8'h0A;
    localparam logic [15:0]      FAULT_VALUE    = 16'hFFFF;

    localparam logic [POS_W-1:0] FIRST_PAYLOAD_POS = 5'd2;
    localparam logic [POS_W-1:0] CHECKSUM_POS      = 5'd20;
    localparam logic [POS_W-1:0] TRAILER_POS       = 5'd21;
    localparam logic [POS_W-1:0] LAST_POS          = 5'd22;

    typedef logic [7:0]  sfd_byte_t;
    typedef logic [15:0] sfd_reading_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_TRAILER = 2'd1,
        STATUS_BAD_SUM     = 2'd2
    } sfd_status_t;

    // Frame tracker view of the byte in the input register.
    typedef struct packed {
        logic last;        // byte is frame byte 22
        logic trailer_ok;  // 0x0D 0x0A trailer seen
        logic sum_ok;      // running sum equals received checksum
    } sfd_frame_t;

endpackage

`default_nettype wire

// File: hw/rtl/sensor_frame_deframer.sv
// ----------------------------------------------------------------------------
// Sensor frame deframer
// Pulls 23-byte sensor frames out of a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one serial byte per
//   request. The block hunts for the sync pair 0x80 0x80, collects frame
//   bytes 2..22, and on frame byte 22 emits one result request on the output
//   channel (out_valid / out_stall): nine big-endian raw readings, a fault
//   mask (reading == 0xFFFF) and a status (ok, bad trailer, bad checksum;
//   the trailer check wins). Bytes that do not finish a frame give nothing.
//   Throughput: one byte per cycle while no frame-ending byte is stalled. Each
//   byte passes through the input register; the result of a frame's last
//   byte is loaded into the output register as that byte leaves the input register.
//   Stall: the output register holds a result until taken. Bytes that do
//   not end a frame keep flowing while a result waits; only a frame-ending
//   byte waits in the input register, and then in_stall rises.
//   Reset (rst_n, async, active low): hunting, no pending request on either
//   side. The payload store is not cleared; it is always written before read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sensor_frame_deframer_defines.svh"

module sensor_frame_deframer
    import sfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      throttle_raw,
    output logic [15:0]      engine_speed_raw,
    output logic [15:0]      cylinder_temp_raw,
    output logic [15:0]      exhaust_temp_raw,
    output logic [15:0]      axle_temp_raw,
    output logic [15:0]      fuel_pressure_raw,
    output logic [15:0]      intake_temp_raw,
    output logic [15:0]      atm_pressure_raw,
    output logic [15:0]      flight_time_raw,
    output logic [8:0]       fault_mask,
    output logic [1:0]       frame_status
);

    // input register
    logic         in_valid_reg, in_valid_next;
    sfd_byte_t    in_byte_reg;
    logic         in_take;

    // pipeline control
    logic         out_free;
    logic         advance;
    logic         load;
    sfd_frame_t   frame;
    sfd_byte_t    payload  [PAYLOAD_BYTES];
    sfd_reading_t readings [READINGS];

    // Output slot is free if empty or being drained this cycle.
    assign out_free = !out_valid || !out_stall;
    // Only a frame-ending byte needs the output slot.
    assign advance  = in_valid_reg && (!frame.last || out_free);
    assign load     = advance && frame.last;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= rx_byte;
    end

    sfd_frame_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .byte_in (in_byte_reg),
        .frame   (frame),
        .payload (payload)
    );

    sfd_result u_result
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .out_stall    (out_stall),
        .frame        (frame),
        .payload      (payload),
        .out_valid    (out_valid),
        .readings     (readings),
        .fault_mask   (fault_mask),
        .frame_status (frame_status)
    );

    assign throttle_raw      = readings[0];
    assign engine_speed_raw  = readings[1];
    assign cylinder_temp_raw = readings[2];
    assign exhaust_temp_raw  = readings[3];
    assign axle_temp_raw     = readings[4];
    assign fuel_pressure_raw = readings[5];
    assign intake_temp_raw   = readings[6];
    assign atm_pressure_raw  = readings[7];
    assign flight_time_raw   = readings[8];

    `SFD_ASSERT_NOW(a_load_slot_free, load, out_free, "result loaded over a held result")
    `SFD_ASSERT_NOW(a_out_rise_loaded, $rose(out_valid), $past(load),
        "result appeared without a frame end")

endmodule

`default_nettype wire

// File: hw/rtl/sfd_frame_ctrl.sv
// ----------------------------------------------------------------------------
// Sensor frame tracker
// Sync hunt, byte position, running checksum and payload byte store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sensor_frame_deframer_defines.svh"

module sfd_frame_ctrl
    import sfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire sfd_byte_t  byte_in,
    output sfd_frame_t      frame,
    output sfd_byte_t       payload [PAYLOAD_BYTES]
);

    logic             sync_reg,  sync_next;
    logic [POS_W-1:0] pos_reg,   pos_next;
    sfd_byte_t        sum_reg,   sum_next;
    sfd_byte_t        chk_reg,   chk_next;
    sfd_byte_t        trail_reg, trail_next;
    sfd_byte_t        payload_reg [PAYLOAD_BYTES];
    logic             hunting;

    assign hunting = (pos_reg < FIRST_PAYLOAD_POS) || (pos_reg > LAST_POS);

    always_comb
    begin
        sync_next  = sync_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        chk_next   = chk_reg;
        trail_next = trail_reg;
        if (advance)
        begin
            priority if (hunting)
            begin
                if (sync_reg && (byte_in == SYNC_BYTE))
                begin
                    sync_next = 1'b0;
                    pos_next  = FIRST_PAYLOAD_POS;
                    sum_next  = SYNC_SUM;
                end
                else
                begin
                    sync_next = (byte_in == SYNC_BYTE);
                    pos_next  = '0;
                end
            end
            else if (pos_reg < CHECKSUM_POS)
            begin
                sum_next = sum_reg + byte_in;
                pos_next = pos_reg + 1'b1;
            end
            else if (pos_reg == CHECKSUM_POS)
            begin
                chk_next = byte_in;
                pos_next = pos_reg + 1'b1;
            end
            else if (pos_reg == TRAILER_POS)
            begin
                trail_next = byte_in;
                pos_next   = pos_reg + 1'b1;
            end
            else
            begin
                // last byte: back to hunting
                pos_next  = '0;
                sync_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg  <= 1'b0;
            pos_reg   <= '0;
            sum_reg   <= '0;
            chk_reg   <= '0;
            trail_reg <= '0;
        end
        else
        begin
            sync_reg  <= sync_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            chk_reg   <= chk_next;
            trail_reg <= trail_next;
        end
    end

    // Each store entry is written at its own frame position.
    for (genvar k = 0; k < PAYLOAD_BYTES; k++)
    begin : g_store
        localparam logic [POS_W-1:0] WR_POS = FIRST_PAYLOAD_POS + POS_W'(k);
        always_ff @(posedge clk)
        begin
            if (advance && (pos_reg == WR_POS))
            begin
                payload_reg[k] <= byte_in;
            end
        end
        assign payload[k] = payload_reg[k];
    end

    assign frame.last       = (pos_reg == LAST_POS);
    assign frame.trailer_ok = (trail_reg == TRAILER_FIRST) && (byte_in == TRAILER_SECOND);
    assign frame.sum_ok     = (sum_reg == chk_reg);

    `SFD_ASSERT_NOW(a_pos_range, 1'b1, pos_reg <= LAST_POS, "frame position out of range")
    `SFD_ASSERT_NEXT(a_frame_end, advance && frame.last, (pos_reg == '0) && !sync_reg,
        "tracker did not return to hunting after frame end")
    `SFD_ASSERT_NEXT(a_sync_start, advance && hunting && sync_reg && (byte_in == SYNC_BYTE),
        (pos_reg == FIRST_PAYLOAD_POS) && (sum_reg == SYNC_SUM), "sync pair not taken")

endmodule

`default_nettype wire

// File: hw/rtl/sfd_result.sv
// ----------------------------------------------------------------------------
// Sensor frame result stage
// Reading assembly, fault mask, status and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_result
    import sfd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire logic          out_stall,
    input  wire sfd_frame_t    frame,
    input  wire sfd_byte_t     payload [PAYLOAD_BYTES],
    output logic               out_valid,
    output sfd_reading_t       readings [READINGS],
    output logic [READINGS-1:0] fault_mask,
    output logic [1:0]         frame_status
);

    logic                valid_reg, valid_next;
    sfd_reading_t        rd_next   [READINGS];
    sfd_reading_t        rd_reg    [READINGS];
    logic [READINGS-1:0] mask_next, mask_reg;
    sfd_status_t         stat_next, stat_reg;

    for (genvar k = 0; k < READINGS; k++)
    begin : g_rd
        assign rd_next[k]   = {payload[2*k], payload[2*k+1]};
        assign mask_next[k] = (rd_next[k] == FAULT_VALUE);
    end

    always_comb
    begin
        priority if (!frame.trailer_ok)
            stat_next = STATUS_BAD_TRAILER;
        else if (!frame.sum_ok)
            stat_next = STATUS_BAD_SUM;
        else
            stat_next = STATUS_OK;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_reg   <= rd_next;
            mask_reg <= mask_next;
            stat_reg <= stat_next;
        end
    end

    assign out_valid    = valid_reg;
    assign readings     = rd_reg;
    assign fault_mask   = mask_reg;
    assign frame_status = stat_reg;

endmodule

`default_nettype wire
